// ===== src/teq_pkg.sv =====
// Shared types and constants for the timed event queue.
// No dependencies.
package teq_pkg;
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TimeW = 48;
  localparam int unsigned TagW = 32;
  localparam int unsigned DelayW = 32;
  localparam int unsigned StepW = 16;
  localparam int unsigned HandleW = 4;
  localparam int unsigned MaxFire = 16;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_SCHED  = 2'd1;
  localparam logic [1:0] REQ_CANCEL = 2'd2;
  localparam logic [1:0] REQ_RSVD   = 2'd3;

  localparam logic [1:0] RES_SCHED  = 2'd0;
  localparam logic [1:0] RES_FIRED  = 2'd1;
  localparam logic [1:0] RES_CANCEL = 2'd2;
  localparam logic [1:0] RES_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [DelayW-1:0]  delay;
    logic [TagW-1:0]    event_tag;
    logic [HandleW-1:0] cancel_handle;
  } req_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [HandleW-1:0] handle;
    logic [TagW-1:0]    fired_tag;
    logic [TimeW-1:0]   lateness;
    logic               last;
  } res_t;
endpackage

// ===== src/teq_if.sv =====
// Valid/ready channel interfaces for the timed event queue.
// Depends on teq_pkg.
interface teq_req_if import teq_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface teq_res_if import teq_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface teq_cfg_if import teq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [StepW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/timed_event_queue.sv =====
// Timed event queue top level: sequencer over slot and order memories.
// Depends on teq_pkg and the interfaces in teq_if.sv.
//
//  channel | dir | payload
//  in_ch   | in  | req_type, delay, event_tag, cancel_handle
//  out_ch  | out | result_kind, handle, fired_tag, lateness, last
//  cfg_ch  | in  | time_step (16 bit)
//
// One request at a time; in_ch is ready only when idle. A list walk visits
// each entry through an order read, a slot read and a compare; a list shift
// reads and then writes each moved entry. A tick fires due events from the
// head, at most sixteen per tick, and ends with a final check.
// Reset clears control state only; memories hold garbage until written.
// A fired event waits in a hold register until the next check shows whether
// it is the last; a full output register stalls the walk at that point.
module timed_event_queue import teq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input logic clk,
  input logic rst_n,
  teq_req_if.sink in_ch,
  teq_res_if.source out_ch,
  teq_cfg_if.sink cfg_ch
);
  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_ORD = 4'd2,
    S_SLOT = 4'd3, S_CMP = 4'd4, S_INS = 4'd5, S_OUT = 4'd6,
    S_SHIFT_RD = 4'd7, S_SHIFT_WR = 4'd8, S_FIN = 4'd9;

  logic [3:0]       st_r;
  req_t             req_r;
  logic [TimeW-1:0] now_r;
  logic [StepW-1:0] step_r;
  logic [QUEUE_DEPTH-1:0] valid_r;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    pos_r;      // walk position
  logic [CW-1:0]    sh_r;       // shift cursor
  logic [IW-1:0]    slot_r;
  logic [TimeW-1:0] due_r;
  logic [4:0]       nfire_r;
  logic             ins_r;      // shift up (insert) vs down (remove)
  logic             hvld_r;     // fired result waiting in hold_r
  res_t             hold_r;
  logic             ovld_r;
  res_t             ores_r;

  // memories
  logic [IW-1:0]    ord_mem [QUEUE_DEPTH];
  logic [TimeW-1:0] due_mem [QUEUE_DEPTH];
  logic [TagW-1:0]  tag_mem [QUEUE_DEPTH];
  logic [IW-1:0]    ord_rd_r;
  logic [TimeW-1:0] due_rd_r;
  logic [TagW-1:0]  tag_rd_r;
  logic             ord_we, slot_we;
  logic [IW-1:0]    ord_wa, ord_ra, ord_wd;

  // walk and output control
  logic [TimeW-1:0] diff;
  logic             at_or_after;
  logic             out_free;
  logic             q_full;
  logic             load_out;
  res_t             out_nxt;

  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    ord_rd_r <= ord_mem[ord_ra];
  end
  // slot read is addressed by the registered order read
  always_ff @(posedge clk) begin
    if (slot_we) begin
      due_mem[slot_r] <= due_r;
      tag_mem[slot_r] <= req_r.event_tag;
    end
    due_rd_r <= due_mem[ord_rd_r];
    tag_rd_r <= tag_mem[ord_rd_r];
  end

  // lowest free slot
  logic [IW-1:0] free_slot;
  always_comb begin
    free_slot = '0;
    for (int i = int'(QUEUE_DEPTH) - 1; i >= 0; i--)
      if (!valid_r[i]) free_slot = IW'(i);
  end

  assign in_ch.ready  = (st_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovld_r;
  assign out_ch.data  = ores_r;

  // memory addressing: insert shifts up from the tail, remove shifts down
  always_comb begin
    ord_ra = pos_r[IW-1:0];
    ord_we = 1'b0;
    ord_wa = pos_r[IW-1:0];
    ord_wd = slot_r;
    slot_we = 1'b0;
    if (st_r == S_SHIFT_RD) begin
      if (ins_r) begin
        ord_ra = IW'(sh_r - 1'b1);
        // gap reached: drop the new slot into the list and store its entry
        if (sh_r == pos_r) begin
          ord_we = 1'b1;
          slot_we = 1'b1;
        end
      end else ord_ra = IW'(sh_r + 1'b1);
    end
    if (st_r == S_SHIFT_WR) begin
      ord_we = 1'b1; ord_wa = sh_r[IW-1:0]; ord_wd = ord_rd_r;
    end
  end

  // wrap-aware compare: tick checks now vs due, schedule checks entry vs new
  always_comb begin
    diff = (req_r.req_type == REQ_TICK) ? now_r - due_rd_r : due_rd_r - due_r;
    at_or_after = !diff[TimeW-1];
    out_free = !ovld_r || out_ch.ready;
    q_full = cnt_r >= CW'(QUEUE_DEPTH);
    load_out = 1'b0;
    out_nxt = hold_r;
    case (st_r)
      S_CMP: load_out = (req_r.req_type == REQ_TICK) && at_or_after && hvld_r && out_free;
      S_OUT: begin
        load_out = out_free;
        if (req_r.req_type == REQ_CANCEL)
          out_nxt = '{RES_CANCEL, HandleW'(slot_r), '0, '0, 1'b1};
        else if (q_full)
          out_nxt = '{RES_FULL, '0, '0, '0, 1'b1};
        else
          out_nxt = '{RES_SCHED, HandleW'(slot_r), '0, '0, 1'b1};
      end
      S_FIN: begin
        load_out = hvld_r && out_free;
        out_nxt.last = 1'b1;
      end
      default: ;
    endcase
  end

  // output register: loads only when empty or leaving in this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (load_out) begin
      ovld_r <= 1'b1;
    end else if (out_ch.ready) begin
      ovld_r <= 1'b0;
    end
    if (load_out) ores_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; now_r <= '0; step_r <= StepW'(1); valid_r <= '0;
      cnt_r <= '0; hvld_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) step_r <= cfg_ch.data;
      unique case (st_r)
        S_IDLE: if (in_ch.valid) begin
          req_r <= in_ch.data; st_r <= S_DISP; pos_r <= '0; nfire_r <= '0;
        end
        S_DISP: begin
          unique case (req_r.req_type)
            REQ_TICK: begin
              now_r <= now_r + TimeW'(step_r); st_r <= S_ORD;
            end
            REQ_SCHED: begin
              slot_r <= free_slot; due_r <= now_r + TimeW'(req_r.delay);
              st_r <= q_full ? S_OUT : S_ORD;
            end
            REQ_CANCEL: begin
              // out-of-range or free slot: dropped without a result
              slot_r <= IW'(req_r.cancel_handle);
              st_r <= (32'(req_r.cancel_handle) < QUEUE_DEPTH &&
                       valid_r[IW'(req_r.cancel_handle)]) ? S_ORD : S_IDLE;
            end
            default: st_r <= S_IDLE;
          endcase
        end
        S_ORD: begin
          if (req_r.req_type == REQ_TICK && (pos_r >= cnt_r || nfire_r == 5'(MaxFire)))
            st_r <= S_FIN;
          else if (pos_r >= cnt_r)
            st_r <= (req_r.req_type == REQ_SCHED) ? S_INS : S_OUT;
          else st_r <= S_SLOT;
        end
        S_SLOT: st_r <= S_CMP;   // order read lands, slot read issued
        S_CMP: begin
          unique case (req_r.req_type)
            REQ_TICK: begin
              if (!at_or_after) begin
                st_r <= S_FIN;
              end else if (!hvld_r || out_free) begin
                // head is due: park it, push the previous one out
                hold_r <= '{RES_FIRED, HandleW'(ord_rd_r), tag_rd_r, diff, 1'b0};
                hvld_r <= 1'b1;
                valid_r[ord_rd_r] <= 1'b0; nfire_r <= nfire_r + 5'd1;
                ins_r <= 1'b0; sh_r <= '0; st_r <= S_SHIFT_RD;
              end
            end
            REQ_SCHED: begin
              // new entry goes ahead of the first one due at or after it
              if (at_or_after) st_r <= S_INS;
              else begin
                pos_r <= pos_r + 1'b1; st_r <= S_ORD;
              end
            end
            default: begin
              if (ord_rd_r == slot_r) begin
                ins_r <= 1'b0; sh_r <= pos_r; st_r <= S_SHIFT_RD;
              end else begin
                pos_r <= pos_r + 1'b1; st_r <= S_ORD;
              end
            end
          endcase
        end
        S_INS: begin
          ins_r <= 1'b1; sh_r <= cnt_r; st_r <= S_SHIFT_RD;
        end
        S_SHIFT_RD: begin
          if (ins_r) begin
            st_r <= (sh_r == pos_r) ? S_OUT : S_SHIFT_WR;
          end else if (sh_r + 1'b1 >= cnt_r) begin
            if (req_r.req_type == REQ_TICK) begin
              cnt_r <= cnt_r - 1'b1; st_r <= S_ORD;
            end else st_r <= S_OUT;
          end else st_r <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          sh_r <= ins_r ? sh_r - 1'b1 : sh_r + 1'b1;
          st_r <= S_SHIFT_RD;
        end
        S_OUT: if (out_free) begin
          if (req_r.req_type == REQ_CANCEL) begin
            valid_r[slot_r] <= 1'b0; cnt_r <= cnt_r - 1'b1;
          end else if (!q_full) begin
            valid_r[slot_r] <= 1'b1; cnt_r <= cnt_r + 1'b1;
          end
          st_r <= S_IDLE;
        end
        S_FIN: begin
          // flush the held fired result with last set, if any
          if (!hvld_r || out_free) begin
            hvld_r <= 1'b0; st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_le: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH)) else $error("count overflow");
  a_cnt_pop: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) == $countones(valid_r) || st_r != S_IDLE) else $error("count mismatch");
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> st_r == S_DISP) else $error("dispatch");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && !out_ch.ready) |=> (ovld_r && $stable(ores_r))) else $error("output hold");
`endif
endmodule
